// ===== hdl/bsi_pkg.sv =====
// Package: widths, payload structs and stage records for the bisector intersect core.
package bsi_pkg;
    localparam int CoordWidth = 16;
    localparam int ParamFracBits = 16;
    localparam int TqWidth = ParamFracBits + 1;
    localparam int DiffWidth = CoordWidth + 1;
    localparam int ProdWidth = 2 * CoordWidth + 3;
    localparam int SumWidth = ProdWidth + 1;
    localparam int CfgIdxWidth = 2;

    localparam logic [CfgIdxWidth-1:0] RegS1x = 2'd0;
    localparam logic [CfgIdxWidth-1:0] RegS1y = 2'd1;
    localparam logic [CfgIdxWidth-1:0] RegS2x = 2'd2;
    localparam logic [CfgIdxWidth-1:0] RegS2y = 2'd3;

    typedef struct packed {
        logic signed [CoordWidth-1:0] seg_start_x;
        logic signed [CoordWidth-1:0] seg_start_y;
        logic signed [CoordWidth-1:0] seg_end_x;
        logic signed [CoordWidth-1:0] seg_end_y;
    } t_in_word;

    typedef struct packed {
        logic                         hit;
        logic signed [CoordWidth-1:0] cross_x;
        logic signed [CoordWidth-1:0] cross_y;
    } t_out_word;

    typedef struct packed {
        logic signed [CoordWidth-1:0] px;
        logic signed [CoordWidth-1:0] py;
        logic signed [DiffWidth-1:0]  dx;
        logic signed [DiffWidth-1:0]  dy;
    } t_seg_info;

    typedef struct packed {
        logic                       ok;
        logic [SumWidth-1:0]        num;
        logic [SumWidth-1:0]        den;
    } t_div_ctl;
endpackage

// ===== hdl/bsi_front.sv =====
// Front end: site differences, numerator/denominator products and sums.
module bsi_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  bsi_pkg::t_in_word            i_word,
    input  logic signed [bsi_pkg::CoordWidth-1:0] i_s1x,
    input  logic signed [bsi_pkg::CoordWidth-1:0] i_s1y,
    input  logic signed [bsi_pkg::CoordWidth-1:0] i_s2x,
    input  logic signed [bsi_pkg::CoordWidth-1:0] i_s2y,
    output logic                         o_valid,
    output bsi_pkg::t_div_ctl            o_ctl,
    output bsi_pkg::t_seg_info           o_seg
);
    import bsi_pkg::*;

    localparam int HWidth = CoordWidth + 2;

    logic                         r_v1, r_v2, r_v3;
    t_seg_info                    r_seg1, r_seg2, r_seg3;
    logic signed [DiffWidth-1:0]  r_a, r_b;
    logic signed [HWidth-1:0]     r_hx, r_hy;
    logic signed [ProdWidth-1:0]  r_pa, r_pb, r_pc, r_pd;
    t_div_ctl                     n_ctl;
    t_div_ctl                     r_ctl;
    logic signed [SumWidth-1:0]   w_num, w_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_seg1.px <= i_word.seg_start_x;
            r_seg1.py <= i_word.seg_start_y;
            r_seg1.dx <= DiffWidth'(i_word.seg_end_x) - DiffWidth'(i_word.seg_start_x);
            r_seg1.dy <= DiffWidth'(i_word.seg_end_y) - DiffWidth'(i_word.seg_start_y);
            r_a  <= DiffWidth'(i_s2x) - DiffWidth'(i_s1x);
            r_b  <= DiffWidth'(i_s2y) - DiffWidth'(i_s1y);
            r_hx <= (HWidth'(i_word.seg_start_x) <<< 1) - HWidth'(i_s1x) - HWidth'(i_s2x);
            r_hy <= (HWidth'(i_word.seg_start_y) <<< 1) - HWidth'(i_s1y) - HWidth'(i_s2y);
            r_seg2 <= r_seg1;
            r_pa <= ProdWidth'(r_a * r_hx);
            r_pb <= ProdWidth'(r_b * r_hy);
            r_pc <= ProdWidth'(r_a * r_seg1.dx);
            r_pd <= ProdWidth'(r_b * r_seg1.dy);
            r_seg3 <= r_seg2;
            r_ctl  <= n_ctl;
        end
    end

    always_comb begin
        w_num = -(SumWidth'(r_pa) + SumWidth'(r_pb));
        w_den = (SumWidth'(r_pc) + SumWidth'(r_pd)) <<< 1;
        n_ctl.ok  = 1'b0;
        n_ctl.num = '0;
        n_ctl.den = '0;
        if (w_den != '0) begin
            if (w_den < 0) begin
                n_ctl.num = SumWidth'(-w_num);
                n_ctl.den = SumWidth'(-w_den);
            end else begin
                n_ctl.num = w_num;
                n_ctl.den = w_den;
            end
            n_ctl.ok = !n_ctl.num[SumWidth-1] && (n_ctl.num <= n_ctl.den);
        end
    end

    assign o_valid = r_v3;
    assign o_ctl   = r_ctl;
    assign o_seg   = r_seg3;
endmodule

// ===== hdl/bsi_div.sv =====
// Pipelined restoring divider producing the Q1.16 parameter, one bit per stage.
module bsi_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  bsi_pkg::t_div_ctl            i_ctl,
    input  bsi_pkg::t_seg_info           i_seg,
    output logic                         o_valid,
    output logic                         o_ok,
    output logic [bsi_pkg::TqWidth-1:0]  o_tq,
    output bsi_pkg::t_seg_info           o_seg
);
    import bsi_pkg::*;

    localparam int Stages = TqWidth;
    localparam int RemWidth = SumWidth + 1;

    logic                r_v   [Stages];
    logic                r_ok  [Stages];
    logic [RemWidth-1:0] r_rem [Stages];
    logic [SumWidth-1:0] r_den [Stages];
    logic [TqWidth-1:0]  r_tq  [Stages];
    t_seg_info           r_seg [Stages];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < Stages; i++) r_v[i] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int i = 1; i < Stages; i++) r_v[i] <= r_v[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        logic [RemWidth-1:0] rem;
        if (i_en) begin
            rem = RemWidth'(i_ctl.num);
            r_ok[0]  <= i_ctl.ok;
            r_den[0] <= i_ctl.den;
            r_seg[0] <= i_seg;
            if (rem >= RemWidth'(i_ctl.den)) begin
                r_rem[0] <= rem - RemWidth'(i_ctl.den);
                r_tq[0]  <= TqWidth'(1);
            end else begin
                r_rem[0] <= rem;
                r_tq[0]  <= '0;
            end
            for (int i = 1; i < Stages; i++) begin
                rem = r_rem[i-1] << 1;
                r_ok[i]  <= r_ok[i-1];
                r_den[i] <= r_den[i-1];
                r_seg[i] <= r_seg[i-1];
                if (rem >= RemWidth'(r_den[i-1])) begin
                    r_rem[i] <= rem - RemWidth'(r_den[i-1]);
                    r_tq[i]  <= {r_tq[i-1][TqWidth-2:0], 1'b1};
                end else begin
                    r_rem[i] <= rem;
                    r_tq[i]  <= {r_tq[i-1][TqWidth-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_v[Stages-1];
    assign o_ok    = r_ok[Stages-1];
    assign o_tq    = r_tq[Stages-1];
    assign o_seg   = r_seg[Stages-1];
endmodule

// ===== hdl/bsi_back.sv =====
// Back end: scale the direction by t and add to the start point.
module bsi_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic                         i_ok,
    input  logic [bsi_pkg::TqWidth-1:0]  i_tq,
    input  bsi_pkg::t_seg_info           i_seg,
    output logic                         o_valid,
    output bsi_pkg::t_out_word           o_word
);
    import bsi_pkg::*;

    localparam int MulWidth = TqWidth + DiffWidth + 1;

    logic                         r_v1, r_v2;
    logic                         r_ok;
    logic signed [CoordWidth-1:0] r_px, r_py;
    logic signed [MulWidth-1:0]   r_mx, r_my;
    t_out_word                    r_word;
    logic signed [MulWidth-1:0]   w_sx, w_sy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    assign w_sx = r_mx >>> ParamFracBits;
    assign w_sy = r_my >>> ParamFracBits;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ok <= i_ok;
            r_px <= i_seg.px;
            r_py <= i_seg.py;
            r_mx <= MulWidth'($signed({1'b0, i_tq}) * i_seg.dx);
            r_my <= MulWidth'($signed({1'b0, i_tq}) * i_seg.dy);
            r_word.hit     <= r_ok;
            r_word.cross_x <= r_ok ? CoordWidth'(r_px + CoordWidth'(w_sx)) : '0;
            r_word.cross_y <= r_ok ? CoordWidth'(r_py + CoordWidth'(w_sy)) : '0;
        end
    end

    assign o_valid = r_v2;
    assign o_word  = r_word;
endmodule

// ===== hdl/bisector_segment_intersect_core.sv =====
// Usage notes for the bisector/segment intersection core:
// Channel in: i_in_valid/o_in_stall with i_in_word (segment start and end).
// Channel out: o_out_valid/i_out_stall with o_out_word (hit, cross_x, cross_y).
// A word moves at a clock edge with valid high and stall low.
// Config: i_cfg_valid/o_cfg_ready, i_cfg_index 0..3 = site one x/y, site two x/y;
// write only while the core is empty. Reset clears sites to zero and all valids.
// Pipeline: 3 front stages, 17 divider stages (one quotient bit each),
// 2 back stages. Throughput: one word/cycle while the output is not stalled.
// The whole pipeline advances together; when the receiver stalls with a
// result waiting, the pipe freezes and o_in_stall rises, so nothing is lost.
// Bubbles advance freely when the output register is empty.
// No hit (including a parallel segment) returns zero crossing coordinates.
module bisector_segment_intersect_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  bsi_pkg::t_in_word                     i_in_word,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output bsi_pkg::t_out_word                    o_out_word,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [bsi_pkg::CfgIdxWidth-1:0]       i_cfg_index,
    input  logic [bsi_pkg::CoordWidth-1:0]        i_cfg_data
);
    import bsi_pkg::*;

    logic signed [CoordWidth-1:0] r_s1x, r_s1y, r_s2x, r_s2y;
    logic        w_en;
    logic        w_fv, w_dv, w_dok;
    t_div_ctl    w_ctl;
    t_seg_info   w_fseg, w_dseg;
    logic [TqWidth-1:0] w_tq;

    assign w_en        = !(o_out_valid && i_out_stall);
    assign o_in_stall  = !w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1x <= '0;
            r_s1y <= '0;
            r_s2x <= '0;
            r_s2y <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                RegS1x:  r_s1x <= i_cfg_data;
                RegS1y:  r_s1y <= i_cfg_data;
                RegS2x:  r_s2x <= i_cfg_data;
                RegS2y:  r_s2y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bsi_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(i_in_valid), .i_word(i_in_word),
        .i_s1x(r_s1x), .i_s1y(r_s1y), .i_s2x(r_s2x), .i_s2y(r_s2y),
        .o_valid(w_fv), .o_ctl(w_ctl), .o_seg(w_fseg)
    );

    bsi_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(w_fv), .i_ctl(w_ctl), .i_seg(w_fseg),
        .o_valid(w_dv), .o_ok(w_dok), .o_tq(w_tq), .o_seg(w_dseg)
    );

    bsi_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(w_dv), .i_ok(w_dok), .i_tq(w_tq), .i_seg(w_dseg),
        .o_valid(o_out_valid), .o_word(o_out_word)
    );
endmodule
